### rtl/battery_protection_manager_top_defines.svh
`ifndef BATTERY_PROTECTION_MANAGER_TOP_DEFINES_SVH
`define BATTERY_PROTECTION_MANAGER_TOP_DEFINES_SVH

// checked outside reset
`define BPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define BPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bpm_pkg.sv
package bpm_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_TEMP_HIGH  = 3'd0;
  localparam logic [2:0] REG_TEMP_LOW   = 3'd1;
  localparam logic [2:0] REG_VOLT_UPPER = 3'd2;
  localparam logic [2:0] REG_VOLT_LOWER = 3'd3;
  localparam logic [2:0] REG_VOLT_DEAD  = 3'd4;

  localparam logic signed [11:0] TEMP_HIGH_RST  = 12'sd600;
  localparam logic signed [11:0] TEMP_LOW_RST   = -12'sd200;
  localparam logic [12:0]        VOLT_UPPER_RST = 13'd4200;
  localparam logic [12:0]        VOLT_LOWER_RST = 13'd3000;
  localparam logic [12:0]        VOLT_DEAD_RST  = 13'd2000;

  localparam logic [1:0] DIR_CHARGE    = 2'd1;
  localparam logic [1:0] DIR_DISCHARGE = 2'd2;
  localparam logic [1:0] FETS_NONE     = 2'b00;
  localparam logic [1:0] FETS_BOTH     = 2'b11;
  localparam logic [1:0] COUNT_MAX     = 2'd3;

  typedef enum logic [1:0] {
    MOS_NONE  = 2'd0,
    MOS_OPEN  = 2'd1,
    MOS_CLOSE = 2'd2
  } mos_cmd_t;

  typedef enum logic [1:0] {
    MASK_NONE  = 2'd0,
    MASK_SET   = 2'd1,
    MASK_CLEAR = 2'd2
  } mask_cmd_t;

  typedef enum logic [1:0] {
    TEMP_OK   = 2'd0,
    TEMP_HOT  = 2'd1,
    TEMP_COLD = 2'd2
  } temp_fault_t;

  typedef struct packed {
    logic signed [11:0] temp_high_limit;
    logic signed [11:0] temp_low_limit;
    logic [12:0]        volt_upper_ok;
    logic [12:0]        volt_lower_ok;
    logic [12:0]        volt_dead_limit;
  } bpm_cfg_t;

  typedef struct packed {
    logic               temp_valid;
    logic signed [11:0] temp_max;
    logic signed [11:0] temp_min;
    logic [12:0]        cell_volt_max;
    logic [12:0]        cell_volt_min;
    logic [1:0]         alert_seen;
    logic [7:0]         volt_fault_bits;
    logic [2:0]         current_fault_bits;
    logic [1:0]         load_alert_bits;
    logic [1:0]         current_direction;
    logic [1:0]         mos_status;
    logic               ext_wake_event;
  } bpm_in_t;

  typedef struct packed {
    mos_cmd_t    mos_command;
    logic        clear_alarm;
    mask_cmd_t   uv_mask_command;
    mask_cmd_t   ov_mask_command;
    logic        retry_wait;
    logic        charge_allowed;
    logic        discharge_allowed;
    temp_fault_t temp_fault;
    logic [9:0]  status_word;
  } bpm_out_t;

endpackage

### rtl/bpm_cfg.sv
module bpm_cfg
  import bpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output bpm_cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[4:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_high_limit <= TEMP_HIGH_RST;
      cfg.temp_low_limit  <= TEMP_LOW_RST;
      cfg.volt_upper_ok   <= VOLT_UPPER_RST;
      cfg.volt_lower_ok   <= VOLT_LOWER_RST;
      cfg.volt_dead_limit <= VOLT_DEAD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TEMP_HIGH:  cfg.temp_high_limit <= signed'(pwdata[11:0]);
        REG_TEMP_LOW:   cfg.temp_low_limit  <= signed'(pwdata[11:0]);
        REG_VOLT_UPPER: cfg.volt_upper_ok   <= pwdata[12:0];
        REG_VOLT_LOWER: cfg.volt_lower_ok   <= pwdata[12:0];
        REG_VOLT_DEAD:  cfg.volt_dead_limit <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TEMP_HIGH:  prdata = {{20{cfg.temp_high_limit[11]}}, cfg.temp_high_limit};
      REG_TEMP_LOW:   prdata = {{20{cfg.temp_low_limit[11]}}, cfg.temp_low_limit};
      REG_VOLT_UPPER: prdata = {19'd0, cfg.volt_upper_ok};
      REG_VOLT_LOWER: prdata = {19'd0, cfg.volt_lower_ok};
      REG_VOLT_DEAD:  prdata = {19'd0, cfg.volt_dead_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/bpm_core.sv
module bpm_core
  import bpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  bpm_cfg_t cfg,
  input  logic     step,
  input  bpm_in_t  req,
  output bpm_out_t res
);

  logic        allow_charge, allow_charge_next;
  logic        allow_discharge, allow_discharge_next;
  logic        uv_masked, uv_masked_next;
  logic        ov_masked, ov_masked_next;
  logic [1:0]  temp_strikes, temp_strikes_next;
  temp_fault_t temp_fault_state, temp_fault_state_next;
  logic [1:0]  overcurrent_retries, overcurrent_retries_next;
  logic        protect_pending, protect_pending_next;
  logic        exit_pending, exit_pending_next;
  logic        wake_pending, wake_pending_next;

  logic      charging, discharging, ov, uv, in_range, open, clear, retry, shut, need_clear;
  mos_cmd_t  mos_cmd;
  mask_cmd_t uv_cmd, ov_cmd;
  logic      pp, ep;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_charge        <= 1'b0;
      allow_discharge     <= 1'b0;
      uv_masked           <= 1'b0;
      ov_masked           <= 1'b0;
      temp_strikes        <= '0;
      temp_fault_state    <= TEMP_OK;
      overcurrent_retries <= '0;
      protect_pending     <= 1'b0;
      exit_pending        <= 1'b0;
      wake_pending        <= 1'b0;
    end else if (step) begin
      allow_charge        <= allow_charge_next;
      allow_discharge     <= allow_discharge_next;
      uv_masked           <= uv_masked_next;
      ov_masked           <= ov_masked_next;
      temp_strikes        <= temp_strikes_next;
      temp_fault_state    <= temp_fault_state_next;
      overcurrent_retries <= overcurrent_retries_next;
      protect_pending     <= protect_pending_next;
      exit_pending        <= exit_pending_next;
      wake_pending        <= wake_pending_next;
    end
  end

  always_comb begin
    charging    = (req.current_direction == DIR_CHARGE);
    discharging = (req.current_direction == DIR_DISCHARGE);
    ov          = |req.volt_fault_bits[7:4];
    uv          = |req.volt_fault_bits[3:0];
    pp          = protect_pending | req.alert_seen[0];
    ep          = exit_pending | req.alert_seen[1];
    wake_pending_next = wake_pending | req.ext_wake_event;

    // temperature debounce
    temp_strikes_next     = temp_strikes;
    temp_fault_state_next = temp_fault_state;
    in_range = (req.temp_max <= cfg.temp_high_limit) &&
               (req.temp_min >= cfg.temp_low_limit);
    if (req.temp_valid) begin
      if (in_range) begin
        temp_strikes_next     = '0;
        temp_fault_state_next = TEMP_OK;
      end else if (temp_strikes != COUNT_MAX) begin
        temp_strikes_next = temp_strikes + 2'd1;
      end else begin
        temp_fault_state_next = (req.temp_max > cfg.temp_high_limit) ? TEMP_HOT : TEMP_COLD;
      end
    end

    // FET decision
    open           = 1'b0;
    clear          = 1'b0;
    uv_cmd         = MASK_NONE;
    ov_cmd         = MASK_NONE;
    uv_masked_next = uv_masked;
    ov_masked_next = ov_masked;
    if (!pp) begin
      if (wake_pending_next) begin
        open              = 1'b1;
        wake_pending_next = 1'b0;
      end
      if (req.load_alert_bits[0]) begin
        open  = 1'b1;
        clear = 1'b1;
      end
    end else begin
      if (allow_charge && uv && charging) begin
        open = 1'b1;
        if (!uv_masked) begin
          uv_cmd         = MASK_SET;
          uv_masked_next = 1'b1;
        end
      end
      if (allow_discharge && ov && discharging) begin
        open = 1'b1;
        if (!ov_masked) begin
          ov_cmd         = MASK_SET;
          ov_masked_next = 1'b1;
        end
      end
    end
    shut = (!allow_discharge && !allow_charge) ||
           (!allow_discharge && allow_charge && discharging) ||
           (allow_discharge && !allow_charge && charging);
    if (open && req.mos_status != FETS_BOTH) begin
      mos_cmd = MOS_OPEN;
    end else if (shut && req.mos_status != FETS_NONE) begin
      mos_cmd = MOS_CLOSE;
    end else begin
      mos_cmd = MOS_NONE;
    end

    // alert recovery
    allow_charge_next        = allow_charge;
    allow_discharge_next     = allow_discharge;
    overcurrent_retries_next = overcurrent_retries;
    protect_pending_next     = pp;
    exit_pending_next        = ep;
    retry                    = 1'b0;
    need_clear               = 1'b0;
    if (pp || ep) begin
      if (req.volt_fault_bits != 8'd0) begin
        if (ov && !uv) begin
          allow_charge_next    = 1'b0;
          allow_discharge_next = 1'b1;
        end
        if (uv && !ov) begin
          allow_discharge_next = 1'b0;
          allow_charge_next    = (req.cell_volt_min >= cfg.volt_dead_limit);
        end
        if (ov && uv) begin
          allow_charge_next    = 1'b0;
          allow_discharge_next = 1'b0;
        end
        if (req.cell_volt_max <= cfg.volt_upper_ok &&
            req.cell_volt_min >= cfg.volt_lower_ok) begin
          allow_charge_next    = 1'b1;
          allow_discharge_next = 1'b1;
          if (ov_masked_next) begin
            ov_cmd         = MASK_CLEAR;
            ov_masked_next = 1'b0;
          end
          if (uv_masked_next) begin
            uv_cmd         = MASK_CLEAR;
            uv_masked_next = 1'b0;
          end
          need_clear = 1'b1;
        end
      end
      if (req.current_fault_bits != 3'd0) begin
        if (overcurrent_retries != COUNT_MAX) begin
          need_clear               = 1'b1;
          retry                    = 1'b1;
          overcurrent_retries_next = overcurrent_retries + 2'd1;
        end else begin
          allow_charge_next    = 1'b0;
          allow_discharge_next = 1'b0;
        end
      end else begin
        overcurrent_retries_next = '0;
      end
      if (req.load_alert_bits != 2'd0) need_clear = 1'b1;
      if (temp_fault_state_next != TEMP_OK) begin
        allow_charge_next    = 1'b0;
        allow_discharge_next = 1'b0;
      end
      if (need_clear) begin
        clear                = 1'b1;
        protect_pending_next = 1'b0;
        exit_pending_next    = 1'b0;
      end
    end

    res.mos_command       = mos_cmd;
    res.clear_alarm       = clear;
    res.uv_mask_command   = uv_cmd;
    res.ov_mask_command   = ov_cmd;
    res.retry_wait        = retry;
    res.charge_allowed    = allow_charge_next;
    res.discharge_allowed = allow_discharge_next;
    res.temp_fault        = temp_fault_state_next;
    res.status_word = {req.current_fault_bits[2], 1'b0,
                       temp_fault_state_next == TEMP_COLD,
                       temp_fault_state_next == TEMP_HOT,
                       req.current_fault_bits[1], req.current_fault_bits[0],
                       uv, ov, req.mos_status[0], req.mos_status[1]};
  end

endmodule

### rtl/battery_protection_manager_top.sv
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | bpm_in_t, one scan pass
// res      | out       | res_valid/res_stall  | bpm_out_t, one result per pass
// apb      | in/out    | psel/penable/pready  | threshold registers at 4*i
//
// One pass per cycle while res_stall is low; a result passes through the request
// register, then the result register.
// Reset (rst, synchronous) restores thresholds and clears all pass state.
// res_stall holds the result; one more request waits in the request register,
// then req_stall rises.
module battery_protection_manager_top
  import bpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  bpm_in_t               req,
  output logic                  res_valid,
  input  logic                  res_stall,
  output bpm_out_t              res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  bpm_cfg_t cfg;
  bpm_in_t  req_q;
  bpm_out_t res_d;
  logic     req_full;
  logic     advance;
  logic     take;

  assign pready    = 1'b1;
  assign advance   = req_full & (~res_valid | ~res_stall);
  assign req_stall = req_full & ~advance;
  assign take      = req_valid & ~req_stall;

  bpm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  bpm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .req  (req_q),
    .res  (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) req_q <= req;
    if (advance) res <= res_d;
  end

endmodule

### rtl/bpm_checker.sv
`include "battery_protection_manager_top_defines.svh"

module bpm_checker
  import bpm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_stall,
  input logic     res_valid,
  input logic     res_stall,
  input bpm_out_t res,
  input logic     pready
);

  logic res_held;
  logic status_ok;

  assign res_held  = res_valid & res_stall;
  assign status_ok = (res.status_word[6] == (res.temp_fault == TEMP_HOT)) &&
                     (res.status_word[7] == (res.temp_fault == TEMP_COLD)) &&
                     !res.status_word[8];

  `BPM_ASSERT_ALWAYS(a_reset_empty, rst |=> (!res_valid && !req_stall), "not empty after reset")
  `BPM_ASSERT(a_res_hold, res_held |=> (res_valid && $stable(res)), "stalled result changed")
  `BPM_ASSERT(a_retry_clears, (res_valid && res.retry_wait) |-> res.clear_alarm, "retry, no clear")
  `BPM_ASSERT(a_status_temp, res_valid |-> status_ok, "status word vs temperature fault")
  `BPM_ASSERT(a_pready, pready, "pready dropped")

endmodule

bind battery_protection_manager_top bpm_checker u_bpm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res),
  .pready    (pready)
);
